// ----- sv/mcma_pkg.sv -----
// Shared constants for the multichannel moving average block.
package mcma_pkg;

    // Result field widths, fixed by the interface.
    localparam int SLOT_W  = 2;
    localparam int VALUE_W = 12;

    // Default configuration.
    localparam int DEF_CHANNELS    = 4;
    localparam int DEF_WINDOW_LOG2 = 3;
    localparam int DEF_SAMPLE_BITS = 12;

endpackage

// ----- sv/mcma_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module mcma_ram #(
    parameter int WIDTH = mcma_pkg::VALUE_W,
    parameter int DEPTH = mcma_pkg::DEF_CHANNELS << mcma_pkg::DEF_WINDOW_LOG2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);
    import mcma_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold the read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/multichannel_moving_average.sv -----
// Top level of the multichannel boxcar moving average.
//
// Input channel (i_in_valid / o_in_ready, payload i_sample): one converter
// reading per request, attributed to the current slot of a round-robin
// rotation over CHANNELS slots, starting at slot 0 after reset.
// Output channel (o_out_valid / i_out_ready): one result per input request,
// carrying the slot the sample was stored for, the raw sample, the average
// of that slot's last 2^WINDOW_LOG2 samples (running sum >> WINDOW_LOG2)
// and the slot to be sampled next, for the multiplexer select.
//
// Throughput: one request per cycle unless the output stalls, set by the
// single read-modify-write of the window RAM (read at accept, write back
// one stage later). A result then passes through the output register.
// The window RAM has one entry per slot and position; a request at one edge
// never touches the entry that the write stage updates in the same cycle.
// Reset: the rotation, write positions and running sums clear at once. The
// window RAM is not swept; a per-slot full flag makes entries of a slot that
// has not yet wrapped read as zero, so no clearing pass is needed.
// Stall: a stalled output holds its register; the write stage still takes
// one more request, then o_in_ready drops until the receiver takes a result.
module multichannel_moving_average #(
    parameter int CHANNELS    = mcma_pkg::DEF_CHANNELS,
    parameter int WINDOW_LOG2 = mcma_pkg::DEF_WINDOW_LOG2,
    parameter int SAMPLE_BITS = mcma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [mcma_pkg::VALUE_W-1:0] i_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mcma_pkg::SLOT_W-1:0]  o_channel,
    output logic [mcma_pkg::VALUE_W-1:0] o_live_value,
    output logic [mcma_pkg::VALUE_W-1:0] o_average,
    output logic [mcma_pkg::SLOT_W-1:0]  o_next_slot
);
    import mcma_pkg::*;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIN_LEN = 1 << WINDOW_LOG2;
    localparam int VAL_W   = (SAMPLE_BITS < VALUE_W) ? SAMPLE_BITS : VALUE_W;
    localparam int SUM_W   = VAL_W + WINDOW_LOG2;
    localparam int DEPTH   = CHANNELS * WIN_LEN;
    localparam int RAM_AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FULL_AW = CH_W + WINDOW_LOG2;

    localparam logic [CH_W-1:0]        LAST_SLOT = CH_W'(CHANNELS - 1);
    localparam logic [WINDOW_LOG2-1:0] LAST_POS  = WINDOW_LOG2'(WIN_LEN - 1);

    // Rotation and per-slot bookkeeping.
    logic [CH_W-1:0]        r_slot;
    logic [WINDOW_LOG2-1:0] r_wpos [CHANNELS];
    logic [CHANNELS-1:0]    r_full;
    logic [SUM_W-1:0]       r_sum  [CHANNELS];

    // Write-back stage.
    logic                   r_s1_valid;
    logic [CH_W-1:0]        r_s1_ch;
    logic [CH_W-1:0]        r_s1_next;
    logic [VAL_W-1:0]       r_s1_val;
    logic                   r_s1_full;
    logic [RAM_AW-1:0]      r_s1_addr;

    // Output register.
    logic                   r_o_valid;
    logic [CH_W-1:0]        r_o_ch;
    logic [CH_W-1:0]        r_o_next;
    logic [VAL_W-1:0]       r_o_val;
    logic [VAL_W-1:0]       r_o_avg;

    logic                   in_accept;
    logic                   s1_adv;
    logic [VAL_W-1:0]       in_val;
    logic [WINDOW_LOG2-1:0] cur_pos;
    logic [CH_W-1:0]        next_slot;
    logic [FULL_AW-1:0]     full_addr;
    logic [RAM_AW-1:0]      rd_addr;
    logic [VAL_W-1:0]       ram_rd_data;
    logic [VAL_W-1:0]       old_val;
    logic [SUM_W-1:0]       n_sum;
    logic [CH_W+SLOT_W-1:0]   ch_ext;
    logic [CH_W+SLOT_W-1:0]   next_ext;
    logic [VAL_W+VALUE_W-1:0] val_ext;
    logic [VAL_W+VALUE_W-1:0] avg_ext;

    // Handshake: the write stage advances whenever the output register is free.
    assign s1_adv     = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // Drop sample bits above SAMPLE_BITS.
    assign in_val    = i_sample[VAL_W-1:0];
    assign cur_pos   = r_wpos[r_slot];
    assign next_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign full_addr = {r_slot, cur_pos};
    assign rd_addr   = full_addr[RAM_AW-1:0];

    // A slot that has not wrapped yet has never written the entry it reads.
    assign old_val = r_s1_full ? ram_rd_data : '0;
    assign n_sum   = r_sum[r_s1_ch] - SUM_W'(old_val) + SUM_W'(r_s1_val);

    mcma_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_window_ram (
        .i_clk     (i_clk),
        .i_we      (s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_val),
        .i_re      (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Advance the rotation and the slot's write position at accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_full <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wpos[c] <= '0;
            end
        end else if (in_accept) begin
            r_slot         <= next_slot;
            r_wpos[r_slot] <= cur_pos + 1'b1;
            if (cur_pos == LAST_POS) begin
                r_full[r_slot] <= 1'b1;
            end
        end
    end

    // Running sums update as the write stage retires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else if (s1_adv) begin
            r_sum[r_s1_ch] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ch   <= r_slot;
            r_s1_next <= next_slot;
            r_s1_val  <= in_val;
            r_s1_full <= r_full[r_slot];
            r_s1_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_ch   <= r_s1_ch;
            r_o_next <= r_s1_next;
            r_o_val  <= r_s1_val;
            r_o_avg  <= n_sum[SUM_W-1:WINDOW_LOG2];
        end
    end

    // Fit internal widths to the fixed result fields.
    assign ch_ext   = {{SLOT_W{1'b0}}, r_o_ch};
    assign next_ext = {{SLOT_W{1'b0}}, r_o_next};
    assign val_ext  = {{VALUE_W{1'b0}}, r_o_val};
    assign avg_ext  = {{VALUE_W{1'b0}}, r_o_avg};

    assign o_out_valid  = r_o_valid;
    assign o_channel    = ch_ext[SLOT_W-1:0];
    assign o_next_slot  = next_ext[SLOT_W-1:0];
    assign o_live_value = val_ext[VALUE_W-1:0];
    assign o_average    = avg_ext[VALUE_W-1:0];

    // The write-back and the new read never hit the same window entry.
    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && in_accept) |-> (r_s1_addr != rd_addr))
        else $error("window RAM read and write collide");

    // An accepted request always occupies the write stage next cycle.
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted request lost before write-back");

    // A retiring write stage always lands in the output register.
    a_s1_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_o_valid)
        else $error("write-back result lost before output");

    // A stalled write stage stays valid and keeps its RAM address.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("write stage changed while stalled");

endmodule

// ----- tb/multichannel_moving_average_checker.sv -----
// Scoreboard for the multichannel moving average: predicts every result and checks it.
`timescale 1ns / 100ps

module multichannel_moving_average_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [mcma_pkg::VALUE_W-1:0] i_sample,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [mcma_pkg::SLOT_W-1:0]  i_channel,
    input  logic [mcma_pkg::VALUE_W-1:0] i_live_value,
    input  logic [mcma_pkg::VALUE_W-1:0] i_average,
    input  logic [mcma_pkg::SLOT_W-1:0]  i_next_slot,
    output int                           o_mismatch_count,
    output int                           o_outstanding
);
    import mcma_pkg::*;

    localparam int CHANNELS     = DEF_CHANNELS;
    localparam int WINDOW_LOG2  = DEF_WINDOW_LOG2;
    localparam int SAMPLE_BITS  = DEF_SAMPLE_BITS;
    localparam int WIN_LEN      = 1 << WINDOW_LOG2;
    localparam int SUM_W        = SAMPLE_BITS + WINDOW_LOG2;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SLOT_W-1:0]  channel;
        logic [VALUE_W-1:0] live_value;
        logic [VALUE_W-1:0] average;
        logic [SLOT_W-1:0]  next_slot;
    } t_avg_result;

    logic [SLOT_W-1:0]      slot_rotation;
    logic [WINDOW_LOG2-1:0] fill_position [CHANNELS];
    logic [SAMPLE_BITS-1:0] window_mem    [CHANNELS][WIN_LEN];
    logic [SUM_W-1:0]       running_sum   [CHANNELS];
    t_avg_result            expected_averages [$];
    int                     mismatch_total = 0;

    task automatic clear_predictor();
        slot_rotation = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            fill_position[c] = '0;
            running_sum[c]   = '0;
            for (int p = 0; p < WIN_LEN; p++) begin
                window_mem[c][p] = '0;
            end
        end
        expected_averages.delete();
    endtask

    // Replace the oldest sample of the current slot and return the result it causes.
    function automatic t_avg_result store_and_average(input logic [VALUE_W-1:0] raw);
        t_avg_result            res;
        logic [SAMPLE_BITS-1:0] val;
        logic [WINDOW_LOG2-1:0] pos;
        int                     ch;
        ch  = slot_rotation;
        val = raw[SAMPLE_BITS-1:0];
        pos = fill_position[ch];
        running_sum[ch]     = running_sum[ch] - window_mem[ch][pos] + val;
        window_mem[ch][pos] = val;
        fill_position[ch]   = pos + 1'b1;
        slot_rotation       = (ch == CHANNELS - 1) ? '0 : SLOT_W'(ch + 1);
        res.channel    = SLOT_W'(ch);
        res.live_value = VALUE_W'(val);
        res.average    = VALUE_W'(running_sum[ch] >> WINDOW_LOG2);
        res.next_slot  = slot_rotation;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_avg_result seen;
        t_avg_result want;
        if (!i_rst_n) begin
            clear_predictor();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen.channel    = i_channel;
                seen.live_value = i_live_value;
                seen.average    = i_average;
                seen.next_slot  = i_next_slot;
                if (expected_averages.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result ch=%0d live=%0d avg=%0d next=%0d",
                                 $time, seen.channel, seen.live_value, seen.average,
                                 seen.next_slot);
                    end
                end else begin
                    want = expected_averages.pop_front();
                    if (seen.channel !== want.channel || seen.live_value !== want.live_value
                        || seen.average !== want.average
                        || seen.next_slot !== want.next_slot) begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT) begin
                            $display("%0t: mismatch expected ch=%0d live=%0d avg=%0d next=%0d",
                                     $time, want.channel, want.live_value, want.average,
                                     want.next_slot);
                            $display("%0t:          actual ch=%0d live=%0d avg=%0d next=%0d",
                                     $time, seen.channel, seen.live_value, seen.average,
                                     seen.next_slot);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_averages.push_back(store_and_average(i_sample));
            end
        end
        o_outstanding    <= expected_averages.size();
        o_mismatch_count <= mismatch_total;
    end

endmodule

// ----- tb/multichannel_moving_average_tb.sv -----
// Testbench top for the multichannel moving average: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module multichannel_moving_average_tb;
    import mcma_pkg::*;

    localparam int RANDOM_SAMPLES = 1800;
    localparam int FULL_SCALE     = (1 << VALUE_W) - 1;

    // Shape of one random segment of samples.
    typedef enum int {
        SEG_UNIFORM,
        SEG_FULL_SCALE,
        SEG_ZERO,
        SEG_RAILS,
        SEG_LOW_CODES
    } t_segment_kind;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [VALUE_W-1:0] i_sample;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [SLOT_W-1:0]  o_channel;
    logic [VALUE_W-1:0] o_live_value;
    logic [VALUE_W-1:0] o_average;
    logic [SLOT_W-1:0]  o_next_slot;

    int   mismatch_count;
    int   results_outstanding;
    logic quiet_link;   // when set, neither side inserts gaps

    always #6 i_clk = ~i_clk;

    multichannel_moving_average dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_channel    (o_channel),
        .o_live_value (o_live_value),
        .o_average    (o_average),
        .o_next_slot  (o_next_slot)
    );

    multichannel_moving_average_checker scoreboard (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_channel        (o_channel),
        .i_live_value     (o_live_value),
        .i_average        (o_average),
        .i_next_slot      (o_next_slot),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (results_outstanding)
    );

    // Pick an idle length: mostly none or a few cycles, now and then a long one.
    function automatic int gap_length();
        int roll;
        if (quiet_link) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_sample(input t_segment_kind kind);
        case (kind)
            SEG_FULL_SCALE: return VALUE_W'(FULL_SCALE);
            SEG_ZERO:       return '0;
            SEG_RAILS:      return $urandom_range(0, 1) ? VALUE_W'(FULL_SCALE) : '0;
            SEG_LOW_CODES:  return VALUE_W'($urandom_range(0, 15));
            default:        return VALUE_W'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    // Present one request at a falling edge and hold it until the block takes it.
    // Leave valid high on return unless an idle gap follows.
    task automatic send_sample(input logic [VALUE_W-1:0] raw);
        int gap;
        i_in_valid <= 1'b1;
        i_sample   <= raw;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        gap = gap_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_sample   <= VALUE_W'($urandom_range(0, FULL_SCALE));   // junk on an idle bus
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop valid and hold off until every predicted result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (results_outstanding != 0);
    endtask

    // Receiver side: toggle ready with random stalls, so gaps land on every phase.
    initial begin : result_sink
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = gap_length();
            if (stall == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // Hard stop in case the handshakes hang.
    initial begin : watchdog
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [VALUE_W-1:0] corner_codes [20];
        t_segment_kind      kind;
        int                 sent;
        int                 seg_len;
        int                 segments;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        quiet_link  = 1'b0;

        // Full scale on every slot, then zero on every slot (rotation wraps both
        // times), then alternating bit patterns, single-bit and near-rail codes, then rails.
        corner_codes = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                         12'h000, 12'h000, 12'h000, 12'h000,
                         12'hAAA, 12'h555, 12'hAAA, 12'h555,
                         12'h800, 12'h001, 12'h7FF, 12'hFFE,
                         12'hFFF, 12'h000, 12'hFFF, 12'h000};

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: run it back to back on the sender side, window not yet full.
        quiet_link = 1'b1;
        foreach (corner_codes[k]) begin
            send_sample(corner_codes[k]);
        end
        quiet_link = 1'b0;

        // Let the pipe empty completely before the random part.
        drain_results();

        // Random part: segments of one shape each. Long full-scale runs fill every
        // window and drive the average to its maximum; zero runs flush it again.
        sent     = 0;
        segments = 0;
        while (sent < RANDOM_SAMPLES) begin
            kind       = t_segment_kind'($urandom_range(0, 4));
            seg_len    = $urandom_range(8, 64);
            quiet_link = ($urandom_range(0, 4) == 0);
            for (int j = 0; j < seg_len; j++) begin
                send_sample(pick_sample(kind));
                sent++;
            end
            segments++;
            if (segments % 10 == 0) begin
                drain_results();
            end
        end
        quiet_link = 1'b0;

        // Wait for the last results, then a few cycles more to catch strays.
        drain_results();
        repeat (8) @(negedge i_clk);

        if (mismatch_count == 0 && results_outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
